// ----- rtl/ssh_pkg.sv -----
// Shared types for the Hibbard-gap Shellsort block.
// Controller state encoding plus the command and status words that join
// ssh_ctrl and ssh_datapath. No dependencies.
package ssh_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_HELD,
    ST_CMP,
    ST_PUT,
    ST_OUT
  } ssh_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // store the input word and bump the count if there is room
    logic gap_init;    // gap := 1, output index := 0
    logic gap_grow;    // gap := 2*gap + 1
    logic pass_start;  // i := gap, read element i
    logic take_held;   // held := element i, j := i, read element j-gap
    logic move;        // element j := element j-gap, j -= gap, read next
    logic put;         // element j := held
    logic next_i;      // i += 1, read element i
    logic next_gap;    // gap /= 2, i := gap, read element i
    logic out_issue;   // read element k for output, k += 1
    logic clear;       // empty the buffer
  } ssh_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic gap_grow_ok; // 2*gap + 1 below the count
    logic n_small;     // fewer than two elements
    logic less;        // held word below the word just read
    logic move_cont;   // after a move, j is still at or above gap
    logic i_last;      // i is the last index of the set
    logic gap_one;     // current pass uses gap 1
    logic k_last;      // output index is the last one
  } ssh_stat_t;

endpackage

// ----- rtl/ssh_ctrl.sv -----
// Controller of the Shellsort block: load, gap search, gapped insertion
// passes and output sequencing. Depends on ssh_pkg.
module ssh_ctrl import ssh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      last_in_i,
  input  ssh_stat_t stat_i,
  output ssh_cmd_t  cmd_o,
  output logic      busy
);

  ssh_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_in_i) begin
            cmd_o.gap_init = 1'b1;
            state_d        = ST_GAP;
          end
        end
      end
      ST_GAP: begin
        if (stat_i.n_small) begin
          state_d = ST_OUT;
        end else if (stat_i.gap_grow_ok) begin
          cmd_o.gap_grow = 1'b1;
        end else begin
          cmd_o.pass_start = 1'b1;
          state_d          = ST_HELD;
        end
      end
      ST_HELD: begin
        cmd_o.take_held = 1'b1;
        state_d         = ST_CMP;
      end
      ST_CMP, ST_PUT: begin
        if (state_q == ST_CMP && stat_i.less) begin
          // shift the larger word up by one gap
          cmd_o.move = 1'b1;
          state_d    = stat_i.move_cont ? ST_CMP : ST_PUT;
        end else begin
          // drop the held word in place and advance
          cmd_o.put = 1'b1;
          if (!stat_i.i_last) begin
            cmd_o.next_i = 1'b1;
            state_d      = ST_HELD;
          end else if (!stat_i.gap_one) begin
            cmd_o.next_gap = 1'b1;
            state_d        = ST_HELD;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        cmd_o.out_issue = 1'b1;
        if (stat_i.k_last) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/ssh_datapath.sv -----
// Datapath of the Shellsort block: element memory, index and gap registers,
// comparator and output register. Depends on ssh_pkg; driven by ssh_ctrl.
module ssh_datapath import ssh_pkg::*; #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ssh_cmd_t    cmd_i,
  input  logic [31:0] value_i,
  output ssh_stat_t   stat_o,
  output logic [31:0] sorted_value_o,
  output logic        last_out_o,
  output logic        result_strobe_o
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
  logic [VALUE_BITS-1:0] rdata_q;
  logic [VALUE_BITS-1:0] held_q;
  logic [VALUE_BITS-1:0] in_word;
  logic [VALUE_BITS-1:0] wdata;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic                  we;
  logic                  re;
  logic [CW-1:0]         count_q;
  logic [IW-1:0]         i_q;
  logic [IW-1:0]         j_q;
  logic [IW-1:0]         gap_q;
  logic [IW-1:0]         k_q;
  logic [IW-1:0]         gap_half;
  logic [CW-1:0]         i_inc;
  logic [CW-1:0]         k_inc;
  logic [CW:0]           gap_grown;
  logic                  room;
  logic                  emit_q;
  logic                  last_q;

  // Fit the input word to the stored width
  if (VALUE_BITS <= 32) begin : g_in_narrow
    assign in_word = value_i[VALUE_BITS-1:0];
  end else begin : g_in_wide
    assign in_word = {{(VALUE_BITS-32){1'b0}}, value_i};
  end

  // Present the stored word on the 32-bit result port
  if (VALUE_BITS >= 32) begin : g_out_wide
    assign sorted_value_o = rdata_q[31:0];
  end else begin : g_out_narrow
    assign sorted_value_o = {{(32-VALUE_BITS){1'b0}}, rdata_q};
  end

  assign room      = (count_q < CW'(MAX_ITEMS));
  assign i_inc     = CW'(i_q) + CW'(1);
  assign k_inc     = CW'(k_q) + CW'(1);
  assign gap_half  = gap_q >> 1;
  assign gap_grown = (CW+1)'({gap_q, 1'b1});

  // Status toward the controller
  always_comb begin
    stat_o.gap_grow_ok = (gap_grown < (CW+1)'(count_q));
    stat_o.n_small     = (count_q < CW'(2));
    stat_o.less        = ($signed(held_q) < $signed(rdata_q));
    stat_o.move_cont   = ((IW+1)'(j_q) >= {gap_q, 1'b0});
    stat_o.i_last      = (i_inc == count_q);
    stat_o.gap_one     = (gap_q == IW'(1));
    stat_o.k_last      = (k_inc == count_q);
  end

  // Select the write port
  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = held_q;
    if (cmd_i.load) begin
      we    = room;
      waddr = count_q[IW-1:0];
      wdata = in_word;
    end else if (cmd_i.move) begin
      we    = 1'b1;
      wdata = rdata_q;
    end else if (cmd_i.put) begin
      we    = 1'b1;
    end
  end

  // Select the read port
  always_comb begin
    re    = 1'b1;
    raddr = '0;
    if (cmd_i.pass_start) begin
      raddr = gap_q;
    end else if (cmd_i.take_held) begin
      raddr = i_q - gap_q;
    end else if (cmd_i.move) begin
      raddr = j_q - gap_q - gap_q;
    end else if (cmd_i.next_i) begin
      raddr = i_inc[IW-1:0];
    end else if (cmd_i.next_gap) begin
      raddr = gap_half;
    end else if (cmd_i.out_issue) begin
      raddr = k_q;
    end else begin
      re    = 1'b0;
    end
  end

  // Element memory, registered read; a read of the word being written returns the new word
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_q <= wdata;
      end else begin
        rdata_q <= mem[raddr];
      end
    end
  end

  // Held word of the current insertion
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_held) begin
      held_q <= rdata_q;
    end
  end

  // Count, indexes and gap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      gap_q   <= IW'(1);
      k_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.load && room) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.gap_init) begin
        gap_q <= IW'(1);
        k_q   <= '0;
      end
      if (cmd_i.gap_grow) begin
        gap_q <= IW'({gap_q, 1'b1});
      end
      if (cmd_i.pass_start) begin
        i_q <= gap_q;
      end
      if (cmd_i.take_held) begin
        j_q <= i_q;
      end
      if (cmd_i.move) begin
        j_q <= j_q - gap_q;
      end
      if (cmd_i.next_i) begin
        i_q <= i_inc[IW-1:0];
      end
      if (cmd_i.next_gap) begin
        gap_q <= gap_half;
        i_q   <= gap_half;
      end
      if (cmd_i.out_issue) begin
        k_q <= k_inc[IW-1:0];
      end
    end
  end

  // Output strobe, registered from the read command so it marks the read word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      emit_q <= cmd_i.out_issue;
      last_q <= cmd_i.out_issue && stat_o.k_last;
    end
  end

  assign result_strobe_o = emit_q;
  assign last_out_o      = last_q;

  // A move never reaches below index zero
  a_move_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |-> (j_q >= gap_q))
    else $error("move issued with j below gap");

  // Output reads stay within the stored set
  a_out_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_issue |-> (CW'(k_q) < count_q))
    else $error("output index beyond element count");

  // Gap never collapses to zero
  a_gap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q != '0)
    else $error("gap reached zero");

  // Last marker only on a strobed word
  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> emit_q)
    else $error("last marker without strobe");

endmodule

// ----- rtl/shell_sort_hibbard_top.sv -----
// Shellsort sorter with Hibbard gaps (1, 3, 7, 15, ...), top level.
// Takes ssh_pkg; instantiates ssh_ctrl and ssh_datapath.
//
// Words are loaded one per cycle while busy is low; the word marked
// last_in_i closes the set (words past MAX_ITEMS are dropped, a last
// marker still closes the set). The block then sorts ascending as signed
// VALUE_BITS-bit numbers and streams the result, one word per cycle on
// result_strobe_o, with last_out_o on the final word. The receiver cannot
// stall: every strobed word must be taken in that cycle. After the last word
// the block searches for the largest Hibbard gap below the count, runs one
// gapped insertion pass per gap down to gap 1, then reads the words out of
// the element memory, which has one write and one registered read port.
module shell_sort_hibbard_top import ssh_pkg::*; #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  input  logic        last_in_i,
  output logic [31:0] sorted_value_o,
  output logic        last_out_o,
  output logic        result_strobe_o
);

  ssh_cmd_t  cmd;
  ssh_stat_t stat;

  ssh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .last_in_i (last_in_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  ssh_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .stat_o          (stat),
    .sorted_value_o  (sorted_value_o),
    .last_out_o      (last_out_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

// ----- tb/ssh_sort_checker.sv -----
// Checker for the Hibbard-gap Shellsort block: watches the load and result ports,
// predicts each sorted set and compares every result word in order.
// Standalone; needs no package and no other testbench file.
module ssh_sort_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] value_i,
  input  logic        last_in_i,
  input  logic [31:0] sorted_value_i,
  input  logic        last_out_i,
  input  logic        result_strobe_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } sorted_word_t;

  sorted_word_t       sorted_words_q[$];
  logic signed [31:0] load_buf [CAPACITY];
  int                 load_count;
  int                 fails;
  int                 checked;

  // Sort load_buf[0..n-1] ascending as signed words, Hibbard gaps, gapped insertion
  function automatic void hibbard_sort(input int n);
    int                 gap;
    int                 i;
    int                 j;
    logic signed [31:0] held;
    gap = 1;
    while (2 * gap + 1 < n) gap = 2 * gap + 1;
    for (; gap > 0; gap = gap / 2) begin
      for (i = gap; i < n; i++) begin
        held = load_buf[i];
        j = i;
        while (j >= gap && held < load_buf[j - gap]) begin
          load_buf[j] = load_buf[j - gap];
          j -= gap;
        end
        load_buf[j] = held;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_word_t want;
    int           k;
    if (!rst_ni) begin
      sorted_words_q.delete();
      load_count = 0;
      fails = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // compare a result word with the oldest prediction
      if (result_strobe_i) begin
        if (sorted_words_q.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", sorted_value_i));
        end else begin
          want = sorted_words_q.pop_front();
          checked++;
          if (sorted_value_i !== want.value)
            report_mismatch($sformatf("word %0d: value %h, expected %h",
                                      checked, sorted_value_i, want.value));
          if (last_out_i !== want.last)
            report_mismatch($sformatf("word %0d: last %b, expected %b",
                                      checked, last_out_i, want.last));
        end
      end
      // take a loaded word; drop it once the buffer is full
      if (start_i && !busy_i) begin
        if (load_count < CAPACITY) begin
          load_buf[load_count] = value_i;
          load_count++;
        end
        // close the set: sort and queue the whole ordered set
        if (last_in_i) begin
          hibbard_sort(load_count);
          for (k = 0; k < load_count; k++) begin
            want.value = load_buf[k];
            want.last = (k == load_count - 1);
            sorted_words_q.push_back(want);
          end
          load_count = 0;
        end
      end
      fail_count_o <= fails;
      pending_o <= sorted_words_q.size();
      checked_o <= checked;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for shell_sort_hibbard_top: clock, reset, word stimulus and verdict.
// Depends on the RTL under rtl/ (ssh_pkg, shell_sort_hibbard_top) and on
// tb/ssh_sort_checker.sv, which predicts and compares the sorted output.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY       = 64;
  localparam int RANDOM_WORDS   = 290;
  localparam int DIRECTED_WORDS = 24;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 50;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] value_i;
  logic        last_in_i;
  logic [31:0] sorted_value_o;
  logic        last_out_o;
  logic        result_strobe_o;

  int          fail_count;
  int          pending;
  int          checked;
  int          words_sent;
  int          sets_sent;
  int          dropped;
  int          stall_cycles;
  bit          idle_ok;
  logic [31:0] prev_word;
  logic [31:0] set_words[$];

  shell_sort_hibbard_top #(
    .MAX_ITEMS (CAPACITY),
    .VALUE_BITS(32)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .last_in_i      (last_in_i),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o),
    .result_strobe_o(result_strobe_o)
  );

  ssh_sort_checker #(
    .CAPACITY(CAPACITY)
  ) u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .value_i        (value_i),
    .last_in_i      (last_in_i),
    .sorted_value_i (sorted_value_o),
    .last_out_i     (last_out_o),
    .result_strobe_i(result_strobe_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_strobe_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic [31:0] v, input logic last);
    if (idle_ok && $urandom_range(99) < 5) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    value_i <= v;
    last_in_i <= last;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  task automatic send_set();
    int idx;
    for (idx = 0; idx < set_words.size(); idx++)
      send_word(set_words[idx], idx == set_words.size() - 1);
    sets_sent++;
    if (set_words.size() > CAPACITY) dropped += set_words.size() - CAPACITY;
  endtask

  // Mix of full-range words, words near zero, extremes, words near the extremes and repeats
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: w = $urandom();
      5, 6: w = 32'($urandom_range(8)) - 32'd4;
      7: begin
        case ($urandom_range(3))
          0: w = 32'h7FFF_FFFF;
          1: w = 32'h8000_0000;
          2: w = 32'h0000_0000;
          default: w = 32'hFFFF_FFFF;
        endcase
      end
      8: w = $urandom_range(1) ? 32'h8000_0000 + 32'($urandom_range(3))
                                : 32'h7FFF_FFFF - 32'($urandom_range(3));
      default: w = prev_word;
    endcase
    prev_word = w;
    return w;
  endfunction

  task automatic build_random_set(input int len);
    set_words.delete();
    repeat (len) set_words.push_back(rand_word());
  endtask

  initial begin
    int len;
    int nset;
    rst_ni = 1'b0;
    start = 1'b0;
    value_i = '0;
    last_in_i = 1'b0;
    idle_ok = 1'b1;
    prev_word = '0;
    words_sent = 0;
    sets_sent = 0;
    dropped = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sets of one at both extremes
    set_words = {32'h7FFF_FFFF};
    send_set();
    set_words = {32'h8000_0000};
    send_set();
    // extremes and sign boundary mixed
    set_words = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF};
    send_set();
    // all equal, then a reversed pair
    set_words = {32'd5, 32'd5, 32'd5};
    send_set();
    set_words = {32'd1, 32'd0};
    send_set();
    // strictly descending across zero, then already ascending
    set_words = {32'd100, 32'd50, 32'd10, 32'd1, 32'd0, 32'hFFFF_FFFF,
                 32'hFFFF_FFCE, 32'h8000_0000};
    send_set();
    set_words = {32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000};
    send_set();

    // random sets: a full buffer, an overflowing one, then mostly small sets
    nset = 0;
    while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
      if (nset == 0) begin
        len = CAPACITY;
      end else if (nset == 1) begin
        len = CAPACITY + 3;
      end else begin
        case ($urandom_range(99) / 5)
          0: len = $urandom_range(CAPACITY + 8, CAPACITY - 4);
          1, 2, 3: len = $urandom_range(40, 13);
          default: len = $urandom_range(12, 1);
        endcase
      end
      // hold a stretch of back-to-back words with no idle at all
      idle_ok = !(words_sent >= 150 && words_sent < 230);
      build_random_set(len);
      send_set();
      nset++;
    end

    // drop start, let the checker see the last word, then drain
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d sets, %0d words loaded, %0d dropped past a full buffer.",
             sets_sent, words_sent, dropped);
    $display("Compared %0d sorted words, from sets of one up to overflowing sets.", checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
